// ===== sv/ezlr_pkg.sv =====
// ----------------------------------------------------------------------------
// ezlr_pkg: shared types and zone helpers for the line rasterizer
// Holds the opcode encoding, the zone numbering used by the front classifier
// and the per-zone direction lookups used by the back stepper.
// ----------------------------------------------------------------------------
package ezlr_pkg;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } opcode_e;

  typedef logic [2:0] octant_t;

  localparam octant_t ZONE_0 = 3'd0;
  localparam octant_t ZONE_1 = 3'd1;
  localparam octant_t ZONE_2 = 3'd2;
  localparam octant_t ZONE_3 = 3'd3;
  localparam octant_t ZONE_4 = 3'd4;
  localparam octant_t ZONE_5 = 3'd5;
  localparam octant_t ZONE_6 = 3'd6;
  localparam octant_t ZONE_7 = 3'd7;

  // Control part of one command passed from front to back
  typedef struct packed {
    logic    is_start;
    octant_t octant;
  } cmd_ctl_t;

  // Major axis is x in the shallow zones
  function automatic logic major_is_x(input octant_t oct);
    logic r;
    case (oct)
      ZONE_0, ZONE_3, ZONE_4, ZONE_7: r = 1'b1;
      default:                        r = 1'b0;
    endcase
    return r;
  endfunction

  // x steps downward in zones 2 to 5
  function automatic logic step_neg_x(input octant_t oct);
    logic r;
    case (oct)
      ZONE_2, ZONE_3, ZONE_4, ZONE_5: r = 1'b1;
      default:                        r = 1'b0;
    endcase
    return r;
  endfunction

  // y steps downward in zones 4 to 7
  function automatic logic step_neg_y(input octant_t oct);
    logic r;
    case (oct)
      ZONE_4, ZONE_5, ZONE_6, ZONE_7: r = 1'b1;
      default:                        r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/ezlr_fifo.sv =====
// ----------------------------------------------------------------------------
// ezlr_fifo: small synchronous queue
// Register-array queue with a fill count; push and pop may happen in the
// same cycle. Callers never push when full nor pop when empty.
// ----------------------------------------------------------------------------
module ezlr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;

  assign full_o  = (count_q == FULL_CNT);
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> (!full_o || pop_i))
    else $error("ezlr_fifo: push while full");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("ezlr_fifo: pop while empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= FULL_CNT)
    else $error("ezlr_fifo: count beyond depth");

endmodule

// ===== sv/ezlr_front.sv =====
// ----------------------------------------------------------------------------
// ezlr_front: input stage and zone classifier
// Registers the incoming item, then classifies start items into a zone
// and the major and minor magnitudes before handing them to the queue.
// ----------------------------------------------------------------------------
module ezlr_front
  import ezlr_pkg::*;
#(
  parameter int COORD_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  opcode_i,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  output logic                  cmd_push_o,
  input  logic                  cmd_full_i,
  output cmd_ctl_t              cmd_ctl_o,
  output logic [COORD_BITS-1:0] cmd_major_o,
  output logic [COORD_BITS-1:0] cmd_minor_o,
  output logic [COORD_BITS-1:0] cmd_x0_o,
  output logic [COORD_BITS-1:0] cmd_y0_o,
  output logic [COORD_BITS-1:0] cmd_x1_o,
  output logic [COORD_BITS-1:0] cmd_y1_o
);

  localparam int C = COORD_BITS;

  logic         valid_q;
  logic         opcode_q;
  logic [C-1:0] x0_q, y0_q, x1_q, y1_q;

  logic signed [C:0] dx, dy;
  logic [C:0]        dx_neg, dy_neg;
  logic [C-1:0]      ax, ay;
  logic              x_wide;
  octant_t           oct;

  assign cmd_push_o = valid_q && !cmd_full_i;
  assign in_ready_o = !valid_q || cmd_push_o;

  // Hold the item until the queue takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      opcode_q <= opcode_i;
      x0_q     <= start_x_i;
      y0_q     <= start_y_i;
      x1_q     <= end_x_i;
      y1_q     <= end_y_i;
    end
  end

  // Classify the zone from signed deltas
  always_comb begin
    dx     = $signed({x1_q[C-1], x1_q}) - $signed({x0_q[C-1], x0_q});
    dy     = $signed({y1_q[C-1], y1_q}) - $signed({y0_q[C-1], y0_q});
    dx_neg = -dx;
    dy_neg = -dy;
    ax     = dx[C] ? dx_neg[C-1:0] : dx[C-1:0];
    ay     = dy[C] ? dy_neg[C-1:0] : dy[C-1:0];
    x_wide = (ax >= ay);
    if (x_wide) begin
      if (!dx[C]) oct = dy[C] ? ZONE_7 : ZONE_0;
      else        oct = dy[C] ? ZONE_4 : ZONE_3;
    end else begin
      if (!dx[C]) oct = dy[C] ? ZONE_6 : ZONE_1;
      else        oct = dy[C] ? ZONE_5 : ZONE_2;
    end
  end

  assign cmd_ctl_o.is_start = (opcode_e'(opcode_q) == OP_START);
  assign cmd_ctl_o.octant   = oct;
  assign cmd_major_o        = x_wide ? ax : ay;
  assign cmd_minor_o        = x_wide ? ay : ax;
  assign cmd_x0_o           = x0_q;
  assign cmd_y0_o           = y0_q;
  assign cmd_x1_o           = x1_q;
  assign cmd_y1_o           = y1_q;

endmodule

// ===== sv/ezlr_back.sv =====
// ----------------------------------------------------------------------------
// ezlr_back: line state and pixel stepper
// Loads the decision variable and increments on a start command and advances
// one pixel per step command while a line is active, in zone-0 mirrored form.
// ----------------------------------------------------------------------------
module ezlr_back
  import ezlr_pkg::*;
#(
  parameter int COORD_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_empty_i,
  output logic                  cmd_pop_o,
  input  cmd_ctl_t              cmd_ctl_i,
  input  logic [COORD_BITS-1:0] cmd_major_i,
  input  logic [COORD_BITS-1:0] cmd_minor_i,
  input  logic [COORD_BITS-1:0] cmd_x0_i,
  input  logic [COORD_BITS-1:0] cmd_y0_i,
  input  logic [COORD_BITS-1:0] cmd_x1_i,
  input  logic [COORD_BITS-1:0] cmd_y1_i,
  input  logic                  out_full_i,
  output logic                  out_push_o,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output octant_t               octant_o,
  output logic                  last_o
);

  localparam int C = COORD_BITS;
  localparam int D = COORD_BITS + 4;

  logic [C-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [C-1:0] tgt_x_q, tgt_y_q;
  logic [D-1:0] dec_q, dec_d, axi_q, dia_q;
  octant_t      oct_q;
  logic         active_q;

  logic         take, do_step;
  logic         mx, nx, ny;
  logic [C-1:0] x_adv, y_adv;
  logic         last;
  logic [D-1:0] u_ext, v2_ext;

  assign take      = !cmd_empty_i && !out_full_i;
  assign cmd_pop_o = take;
  assign do_step   = take && !cmd_ctl_i.is_start && active_q;

  // Step one pixel: axial move on negative decision, else diagonal
  always_comb begin
    mx      = major_is_x(oct_q);
    nx      = step_neg_x(oct_q);
    ny      = step_neg_y(oct_q);
    x_adv   = nx ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
    y_adv   = ny ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    if (dec_q[D-1]) begin
      dec_d = dec_q + axi_q;
      if (mx) cur_x_d = x_adv;
      else    cur_y_d = y_adv;
    end else begin
      dec_d   = dec_q + dia_q;
      cur_x_d = x_adv;
      cur_y_d = y_adv;
    end
    last = mx ? (cur_x_d == tgt_x_q) : (cur_y_d == tgt_y_q);
  end

  assign u_ext  = D'(cmd_major_i);
  assign v2_ext = D'({cmd_minor_i, 1'b0});

  // Load a new line or advance the active one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      tgt_x_q  <= '0;
      tgt_y_q  <= '0;
      dec_q    <= '0;
      axi_q    <= '0;
      dia_q    <= '0;
      oct_q    <= ZONE_0;
      active_q <= 1'b0;
    end else if (take && cmd_ctl_i.is_start) begin
      cur_x_q  <= cmd_x0_i;
      cur_y_q  <= cmd_y0_i;
      tgt_x_q  <= cmd_x1_i;
      tgt_y_q  <= cmd_y1_i;
      dec_q    <= v2_ext - u_ext;
      axi_q    <= v2_ext;
      dia_q    <= v2_ext - (u_ext << 1);
      oct_q    <= cmd_ctl_i.octant;
      active_q <= (cmd_major_i != '0);
    end else if (do_step) begin
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      dec_q   <= dec_d;
      if (last) begin
        active_q <= 1'b0;
      end
    end
  end

  assign out_push_o = do_step;
  assign pixel_x_o  = cur_x_d;
  assign pixel_y_o  = cur_y_d;
  assign octant_o   = oct_q;
  assign last_o     = last;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (do_step && last) |=> !active_q)
    else $error("ezlr_back: line still active after last pixel");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (take && cmd_ctl_i.is_start && cmd_major_i != '0) |=> active_q)
    else $error("ezlr_back: nonzero line failed to start");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_push_o |-> (active_q && !out_full_i))
    else $error("ezlr_back: pixel pushed without active line or room");

endmodule

// ===== sv/eight_zone_line_rasterizer_core.sv =====
// ----------------------------------------------------------------------------
// Path: a step item's pixel reaches the result ports through the input
// register, the command queue, and the stepper into the result queue.
// Throughput: one item per cycle unless a queue is full; a step is one decision
// add and one or two coordinate increments, with queues decoupling both sides.
// Reset: asynchronous, active low; clears queues and returns to no line.
// ----------------------------------------------------------------------------
// eight_zone_line_rasterizer_core: eight-zone midpoint line rasterizer
// Front classifies start items; back steps the line and emits pixels.
// ----------------------------------------------------------------------------
module eight_zone_line_rasterizer_core
  import ezlr_pkg::*;
#(
  parameter int COORD_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic                  opcode_i,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic [2:0]            octant_o,
  output logic                  last_pixel_o
);

  localparam int C     = COORD_BITS;
  localparam int CTL_W = $bits(cmd_ctl_t);
  localparam int CMD_W = CTL_W + 6 * C;
  localparam int OUT_W = 2 * C + 4;

  logic         in_ready;
  logic         cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_ctl_t     f_ctl, b_ctl;
  logic [C-1:0] f_major, f_minor, f_x0, f_y0, f_x1, f_y1;
  logic [C-1:0] b_major, b_minor, b_x0, b_y0, b_x1, b_y1;
  logic [CMD_W-1:0] cmd_wdata, cmd_rdata;

  logic         out_push, out_full, b_last;
  logic [C-1:0] b_px, b_py;
  octant_t      b_oct;
  logic [OUT_W-1:0] out_wdata, out_rdata;

  assign full = !in_ready;

  ezlr_front #(.COORD_BITS(C)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (push),
    .in_ready_o  (in_ready),
    .opcode_i    (opcode_i),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .cmd_push_o  (cmd_push),
    .cmd_full_i  (cmd_full),
    .cmd_ctl_o   (f_ctl),
    .cmd_major_o (f_major),
    .cmd_minor_o (f_minor),
    .cmd_x0_o    (f_x0),
    .cmd_y0_o    (f_y0),
    .cmd_x1_o    (f_x1),
    .cmd_y1_o    (f_y1)
  );

  // Pack commands into the decoupling queue
  assign cmd_wdata = {f_ctl, f_major, f_minor, f_x0, f_y0, f_x1, f_y1};
  assign {b_ctl, b_major, b_minor, b_x0, b_y0, b_x1, b_y1} = cmd_rdata;

  ezlr_fifo #(.WIDTH(CMD_W), .DEPTH(2)) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_wdata),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_rdata),
    .empty_o (cmd_empty)
  );

  ezlr_back #(.COORD_BITS(C)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .cmd_ctl_i   (b_ctl),
    .cmd_major_i (b_major),
    .cmd_minor_i (b_minor),
    .cmd_x0_i    (b_x0),
    .cmd_y0_i    (b_y0),
    .cmd_x1_i    (b_x1),
    .cmd_y1_i    (b_y1),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .pixel_x_o   (b_px),
    .pixel_y_o   (b_py),
    .octant_o    (b_oct),
    .last_o      (b_last)
  );

  // Queue results toward the consumer
  assign out_wdata = {b_px, b_py, b_oct, b_last};
  assign {pixel_x_o, pixel_y_o, octant_o, last_pixel_o} = out_rdata;

  ezlr_fifo #(.WIDTH(OUT_W), .DEPTH(2)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_wdata),
    .full_o  (out_full),
    .pop_i   (pop && !empty),
    .data_o  (out_rdata),
    .empty_o (empty)
  );

endmodule

// ===== tb/sv/eight_zone_line_rasterizer_core_test.sv =====
// ----------------------------------------------------------------------------
// eight_zone_line_rasterizer_core_test: self-checking bench for the rasterizer
// Drives start and step items through the push side and pops pixels on the
// other side. A behavioral line tracer in the bench predicts every pixel.
// Directed lines cover each zone, the diagonal ties, the axis-aligned cases
// and the coordinate extremes. Random lines follow, mostly walked to their
// end, with random idle bursts on both sides and a quiet tail.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eight_zone_line_rasterizer_core_test;
  import ezlr_pkg::*;

  localparam int CW = 10;
  localparam int C_MIN = -(1 << (CW - 1));
  localparam int C_MAX = (1 << (CW - 1)) - 1;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    octant_t       zone;
    logic          last;
  } pixel_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          push = 1'b0;
  logic          full;
  logic          opcode_i = OP_START;
  logic [CW-1:0] start_x_i = '0;
  logic [CW-1:0] start_y_i = '0;
  logic [CW-1:0] end_x_i = '0;
  logic [CW-1:0] end_y_i = '0;
  logic          empty;
  logic          pop = 1'b0;
  logic [CW-1:0] pixel_x_o;
  logic [CW-1:0] pixel_y_o;
  logic [2:0]    octant_o;
  logic          last_pixel_o;

  eight_zone_line_rasterizer_core #(.COORD_BITS(CW)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .opcode_i    (opcode_i),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .empty       (empty),
    .pop         (pop),
    .pixel_x_o   (pixel_x_o),
    .pixel_y_o   (pixel_y_o),
    .octant_o    (octant_o),
    .last_pixel_o(last_pixel_o)
  );

  always #6 clk_i = ~clk_i;

  // Tracer state: pen position, goal, decision terms, zone, line in flight
  logic signed [CW-1:0]   pen_x, pen_y, goal_x, goal_y;
  logic signed [CW+3:0]   err_term, err_axial, err_diag;
  octant_t                pen_zone;
  logic                   drawing;

  pixel_t pending_pixels[$];
  int     errors = 0;
  bit     tail_phase = 1'b0;

  function automatic octant_t zone_of(int dx, int dy);
    int ax, ay;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (ax >= ay) begin
      if (dx >= 0) return (dy >= 0) ? ZONE_0 : ZONE_7;
      return (dy >= 0) ? ZONE_3 : ZONE_4;
    end
    if (dx >= 0) return (dy >= 0) ? ZONE_1 : ZONE_6;
    return (dy >= 0) ? ZONE_2 : ZONE_5;
  endfunction

  function automatic bit shallow(octant_t z);
    return (z == ZONE_0) || (z == ZONE_3) || (z == ZONE_4) || (z == ZONE_7);
  endfunction

  function automatic int dir_x(octant_t z);
    return (z >= ZONE_2 && z <= ZONE_5) ? -1 : 1;
  endfunction

  function automatic int dir_y(octant_t z);
    return (z >= ZONE_4) ? -1 : 1;
  endfunction

  // Advance the tracer by one accepted item; queue the pixel it yields
  function automatic void trace_item(logic op, logic [CW-1:0] sx, logic [CW-1:0] sy,
                                     logic [CW-1:0] ex, logic [CW-1:0] ey);
    int     x0, y0, x1, y1, dx, dy, u, v, nx, ny;
    octant_t z;
    bit     hit;
    pixel_t px;
    if (op == OP_START) begin
      x0 = int'($signed(sx));
      y0 = int'($signed(sy));
      x1 = int'($signed(ex));
      y1 = int'($signed(ey));
      dx = x1 - x0;
      dy = y1 - y0;
      z = zone_of(dx, dy);
      u = shallow(z) ? dx : dy;
      v = shallow(z) ? dy : dx;
      u = (u < 0) ? -u : u;
      v = (v < 0) ? -v : v;
      pen_x = sx;
      pen_y = sy;
      goal_x = ex;
      goal_y = ey;
      err_term = (CW + 4)'(2 * v - u);
      err_axial = (CW + 4)'(2 * v);
      err_diag = (CW + 4)'(2 * (v - u));
      pen_zone = z;
      drawing = (u != 0);
      return;
    end
    if (!drawing) return;
    z = pen_zone;
    nx = int'(pen_x);
    ny = int'(pen_y);
    if (err_term < 0) begin
      err_term = err_term + err_axial;
      if (shallow(z)) nx = nx + dir_x(z);
      else ny = ny + dir_y(z);
    end else begin
      err_term = err_term + err_diag;
      nx = nx + dir_x(z);
      ny = ny + dir_y(z);
    end
    pen_x = nx[CW-1:0];
    pen_y = ny[CW-1:0];
    hit = shallow(z) ? (pen_x == goal_x) : (pen_y == goal_y);
    if (hit) drawing = 1'b0;
    px.x = pen_x;
    px.y = pen_y;
    px.zone = z;
    px.last = hit;
    pending_pixels.push_back(px);
  endfunction

  // Send one item; optionally idle first, hold push high until accepted
  task automatic push_item(logic op, int sx, int sy, int ex, int ey);
    int gap;
    if (!tail_phase && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk_i);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push <= 1'b1;
    opcode_i <= op;
    start_x_i <= sx[CW-1:0];
    start_y_i <= sy[CW-1:0];
    end_x_i <= ex[CW-1:0];
    end_y_i <= ey[CW-1:0];
    do @(posedge clk_i); while (full);
    trace_item(op, sx[CW-1:0], sy[CW-1:0], ex[CW-1:0], ey[CW-1:0]);
  endtask

  task automatic step_line(int n);
    repeat (n) push_item(OP_STEP, int'($urandom_range(0, 1023)), int'($urandom_range(0, 1023)),
                         int'($urandom_range(0, 1023)), int'($urandom_range(0, 1023)));
  endtask

  // Receiver: random pop bursts, steady pop in the tail
  initial begin
    int  left;
    bit  stall;
    left = 0;
    stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (left == 0) begin
        stall = ($urandom_range(0, 2) == 0);
        left = $urandom_range(1, 16);
      end
      left--;
      pop <= (tail_phase || !rst_ni) ? 1'b1 : !stall;
    end
  end

  task automatic report_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Compare each popped pixel with the oldest prediction
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t unexpected pixel: expected none, got x=%0d y=%0d zone=%0d last=%0b",
                 $time, $signed(pixel_x_o), $signed(pixel_y_o), octant_o, last_pixel_o);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        report_field("pixel_x", int'($signed(want.x)), int'($signed(pixel_x_o)));
        report_field("pixel_y", int'($signed(want.y)), int'($signed(pixel_y_o)));
        report_field("octant", int'(want.zone), int'(octant_o));
        report_field("last_pixel", int'(want.last), int'(last_pixel_o));
      end
    end
  end

  // Steps with no line after reset, then a zero-length line
  task automatic test_idle_steps();
    step_line(1);
    push_item(OP_START, 0, 0, 0, 0);
    step_line(1);
  endtask

  // Diagonal ties in several zones, walked to the coordinate extremes
  task automatic test_zone_ties();
    push_item(OP_START, 508, -512, 511, -509);
    step_line(4);
    push_item(OP_START, -509, 511, -512, 508);
    step_line(3);
    push_item(OP_START, 0, 0, 2, -2);
    step_line(1);
    push_item(OP_START, 0, 0, -2, 2);
    step_line(1);
  endtask

  // Remaining zones, axis-aligned lines, far endpoints, line replaced midway
  task automatic test_zones_and_axes();
    push_item(OP_START, C_MIN, C_MIN, C_MAX, C_MAX);
    step_line(1);
    push_item(OP_START, 0, 0, 0, 3);
    step_line(1);
    push_item(OP_START, C_MIN, C_MAX, C_MIN, C_MIN);
    step_line(1);
    push_item(OP_START, 5, 0, 4, 9);
    step_line(1);
    push_item(OP_START, 0, 0, -1, -7);
    step_line(1);
    push_item(OP_START, C_MAX, 5, C_MIN, 5);
    step_line(1);
  endtask

  function automatic int clamp_coord(int c);
    if (c > C_MAX) return C_MAX;
    if (c < C_MIN) return C_MIN;
    return c;
  endfunction

  // Random lines: mostly short ones walked to the end, some cut off,
  // some far lines stepped briefly, plus random noise items
  task automatic test_random_lines(int n_items);
    int sent, kind, sx, sy, ex, ey, ax, ay, steps;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        push_item(1'($urandom_range(0, 1)), int'($urandom_range(0, 1023)),
                  int'($urandom_range(0, 1023)), int'($urandom_range(0, 1023)),
                  int'($urandom_range(0, 1023)));
        sent++;
      end else begin
        sx = int'($urandom_range(0, 1023)) + C_MIN;
        sy = int'($urandom_range(0, 1023)) + C_MIN;
        if (kind == 1) begin
          ex = int'($urandom_range(0, 1023)) + C_MIN;
          ey = int'($urandom_range(0, 1023)) + C_MIN;
          steps = $urandom_range(1, 24);
        end else begin
          ex = clamp_coord(sx + int'($urandom_range(0, 40)) - 20);
          ey = clamp_coord(sy + int'($urandom_range(0, 40)) - 20);
          ax = (ex > sx) ? ex - sx : sx - ex;
          ay = (ey > sy) ? ey - sy : sy - ey;
          steps = (ax > ay) ? ax : ay;
          if ($urandom_range(0, 9) == 0) steps = steps / 2;
          else steps = steps + $urandom_range(0, 2);
        end
        push_item(OP_START, sx, sy, ex, ey);
        step_line(steps);
        sent += steps + 1;
      end
    end
  endtask

  initial begin
    pen_x = '0;
    pen_y = '0;
    goal_x = '0;
    goal_y = '0;
    err_term = '0;
    err_axial = '0;
    err_diag = '0;
    pen_zone = ZONE_0;
    drawing = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_idle_steps();
    test_zone_ties();
    test_zones_and_axes();
    test_random_lines(720);
    tail_phase = 1'b1;
    test_random_lines(150);

    // Drop push, drain the result side, then allow the pipeline to settle
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog against a hung handshake
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
